/* rtl/lmct_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and status codes for the lock mode compatibility table.
// Used by lock_mode_compat_table; depends on nothing.
package lmct_pkg;
  localparam int DefRequestSlots = 16;
  localparam int DefModeCount    = 8;
  localparam int DefHolderSlots  = 16;

  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_WAITING  = 3'd1;
  localparam logic [2:0] ST_TIMEOUT  = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_WOKEN    = 3'd6;

  localparam logic OP_LOCK   = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;
endpackage

/* rtl/lock_mode_compat_table.sv */
`timescale 1ns / 1ps
// Lock table for one entity: grant, queue, release and wake of lock requests.
// A lock runs the holder search before its decision; a bad or waiter unlock does not. A granted
// unlock runs the search, then checks the wait queue entry by entry and runs the search again
// for each waiter that does not conflict (a waiter with no holder room stays queued).
// The holder search shares one 64-bit comparator, one entry a cycle. One word at a time:
// busy falls in the cycle the last result is shown; the receiver cannot stall. Sync reset.
module lock_mode_compat_table
  import lmct_pkg::*;
#(
  parameter int REQUEST_SLOTS = lmct_pkg::DefRequestSlots,
  parameter int MODE_COUNT    = lmct_pkg::DefModeCount,
  parameter int HOLDER_SLOTS  = lmct_pkg::DefHolderSlots
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [63:0] txn_id,
  input  logic [2:0]  lock_mode,
  input  logic        no_wait,
  input  logic [3:0]  request_handle,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [3:0]  handle,
  output logic [63:0] woken_txn,
  output logic [7:0]  granted_modes,
  output logic [7:0]  waiting_modes,
  output logic        last
);
  localparam int SW = $clog2(REQUEST_SLOTS);
  localparam int HW = $clog2(HOLDER_SLOTS);
  localparam int CW = $clog2(REQUEST_SLOTS + 1);
  localparam int LW = $clog2(REQUEST_SLOTS + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UNLOCK   = 4'd1;
  localparam logic [3:0] S_HSCAN    = 4'd2;
  localparam logic [3:0] S_LOCK_DEC = 4'd3;
  localparam logic [3:0] S_REL_DEC  = 4'd4;
  localparam logic [3:0] S_WCHECK   = 4'd5;
  localparam logic [3:0] S_WAKE_DEC = 4'd6;
  localparam logic [3:0] S_STAGE    = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  logic [3:0]  state, scan_ret, stage_ret;
  logic [63:0] conflict_matrix;
  logic [REQUEST_SLOTS-1:0] slot_used, slot_is_waiting;
  logic [2:0]  slot_mode [REQUEST_SLOTS];
  logic [63:0] slot_txn [REQUEST_SLOTS];
  logic [SW-1:0] wait_queue [REQUEST_SLOTS];
  logic [LW-1:0] wait_length;
  logic [CW-1:0] granted_cnt [MODE_COUNT];
  logic [CW-1:0] waiting_cnt [MODE_COUNT];
  logic [63:0] holder_txn [HOLDER_SLOTS];
  logic [CW-1:0] holder_grants [HOLDER_SLOTS];

  // Latched request.
  logic        req_nowait;
  logic        req_bad;
  logic [2:0]  req_mode;
  logic [SW-1:0] req_slot;
  logic [63:0] key;

  // Holder search.
  logic [HW-1:0] hi;
  logic        found_v, free_v;
  logic [HW-1:0] found_idx, free_idx;

  // Wake scan.
  logic [LW-1:0] qi;
  logic [SW-1:0] wake_slot;

  // Event just produced and the word waiting to go out.
  logic [2:0]  ev_status;
  logic [SW-1:0] ev_handle;
  logic [63:0] ev_txn;
  logic        pend_valid;
  logic [2:0]  pend_status;
  logic [SW-1:0] pend_handle;
  logic [63:0] pend_txn;
  logic [7:0]  pend_g, pend_w;

  logic [7:0]  gmask, wmask;
  logic [2:0]  in_mode;
  logic [SW-1:0] free_slot;
  logic        free_slot_v;
  logic [SW-1:0] q_pos;
  logic        q_hit;
  logic        hmatch;
  logic [SW-1:0] q_head;
  logic [2:0]  q_mode;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    gmask = '0;
    wmask = '0;
    for (int m = 0; m < MODE_COUNT; m++) begin
      gmask[m] = (granted_cnt[m] != '0);
      wmask[m] = (waiting_cnt[m] != '0);
    end
  end

  function automatic logic conflicts(input logic [63:0] cm, input logic [2:0] md,
                                     input logic [7:0] gm);
    return (cm[{md, 3'b000} +: 8] & gm) != 8'd0;
  endfunction

  assign in_mode = (32'(lock_mode) >= MODE_COUNT) ? 3'(MODE_COUNT - 1) : lock_mode;

  always_comb begin
    free_slot   = '0;
    free_slot_v = 1'b0;
    for (int i = REQUEST_SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_slot   = SW'(i);
        free_slot_v = 1'b1;
      end
    end
  end

  always_comb begin
    q_pos = '0;
    q_hit = 1'b0;
    for (int i = 0; i < REQUEST_SLOTS; i++) begin
      if (!q_hit && (LW'(i) < wait_length) && (wait_queue[i] == req_slot)) begin
        q_pos = SW'(i);
        q_hit = 1'b1;
      end
    end
  end

  // The one shared comparator of the holder search.
  assign hmatch = (holder_txn[hi] == key);
  assign q_head = wait_queue[qi[SW-1:0]];
  assign q_mode = slot_mode[q_head];

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      conflict_matrix <= '0;
      slot_used       <= '0;
      slot_is_waiting <= '0;
      wait_length     <= '0;
      pend_valid      <= 1'b0;
      result_valid    <= 1'b0;
      for (int m = 0; m < MODE_COUNT; m++) begin
        granted_cnt[m] <= '0;
        waiting_cnt[m] <= '0;
      end
      for (int h = 0; h < HOLDER_SLOTS; h++) begin
        holder_grants[h] <= '0;
      end
    end else begin
      result_valid <= (state == S_FINISH) || ((state == S_STAGE) && pend_valid);
      if (cfg_valid && cfg_ready) begin
        conflict_matrix <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_nowait <= no_wait;
            req_mode   <= in_mode;
            req_bad    <= (32'(request_handle) >= REQUEST_SLOTS);
            req_slot   <= (32'(request_handle) >= REQUEST_SLOTS) ? '0 : SW'(request_handle);
            key        <= txn_id;
            hi         <= '0;
            found_v    <= 1'b0;
            free_v     <= 1'b0;
            if (operation == OP_LOCK) begin
              scan_ret <= S_LOCK_DEC;
              state    <= S_HSCAN;
            end else begin
              state <= S_UNLOCK;
            end
            ev_handle <= SW'(request_handle);
          end
        end
        S_UNLOCK: begin
          ev_txn    <= '0;
          stage_ret <= S_FINISH;
          if (req_bad || !slot_used[req_slot]) begin
            ev_status <= ST_BAD;
            state     <= S_STAGE;
          end else if (slot_is_waiting[req_slot]) begin
            if (q_hit) begin
              for (int i = 0; i < REQUEST_SLOTS - 1; i++) begin
                if (SW'(i) >= q_pos) wait_queue[i] <= wait_queue[i+1];
              end
              wait_length <= wait_length - 1'b1;
            end
            if (waiting_cnt[slot_mode[req_slot]] != '0) begin
              waiting_cnt[slot_mode[req_slot]] <= waiting_cnt[slot_mode[req_slot]] - 1'b1;
            end
            slot_used[req_slot]       <= 1'b0;
            slot_is_waiting[req_slot] <= 1'b0;
            ev_status <= ST_RELEASED;
            state     <= S_STAGE;
          end else begin
            if (granted_cnt[slot_mode[req_slot]] != '0) begin
              granted_cnt[slot_mode[req_slot]] <= granted_cnt[slot_mode[req_slot]] - 1'b1;
            end
            slot_used[req_slot] <= 1'b0;
            key      <= slot_txn[req_slot];
            scan_ret <= S_REL_DEC;
            state    <= S_HSCAN;
          end
        end
        S_HSCAN: begin
          if (holder_grants[hi] != '0) begin
            if (hmatch && !found_v) begin
              found_v   <= 1'b1;
              found_idx <= hi;
            end
          end else if (!free_v) begin
            free_v   <= 1'b1;
            free_idx <= hi;
          end
          hi <= hi + 1'b1;
          if (32'(hi) == HOLDER_SLOTS - 1) begin
            state <= scan_ret;
          end
        end
        S_LOCK_DEC: begin
          logic grant;
          logic [HW-1:0] h;
          grant = found_v || (!conflicts(conflict_matrix, req_mode, gmask) &&
                              wait_length == '0);
          h = found_v ? found_idx : free_idx;
          ev_txn    <= '0;
          stage_ret <= S_FINISH;
          state     <= S_STAGE;
          if (!grant && req_nowait) begin
            ev_status <= ST_TIMEOUT;
            ev_handle <= '0;
          end else if (!free_slot_v || (grant && !found_v && !free_v)) begin
            ev_status <= ST_FULL;
            ev_handle <= '0;
          end else begin
            ev_handle <= free_slot;
            slot_used[free_slot] <= 1'b1;
            slot_mode[free_slot] <= req_mode;
            slot_txn[free_slot]  <= key;
            if (grant) begin
              slot_is_waiting[free_slot] <= 1'b0;
              holder_txn[h]        <= key;
              holder_grants[h]     <= holder_grants[h] + 1'b1;
              granted_cnt[req_mode] <= granted_cnt[req_mode] + 1'b1;
              ev_status <= ST_GRANTED;
            end else begin
              slot_is_waiting[free_slot] <= 1'b1;
              if (32'(wait_length) < REQUEST_SLOTS) begin
                wait_queue[wait_length[SW-1:0]] <= free_slot;
                wait_length <= wait_length + 1'b1;
              end
              waiting_cnt[req_mode] <= waiting_cnt[req_mode] + 1'b1;
              ev_status <= ST_WAITING;
            end
          end
        end
        S_REL_DEC: begin
          if (found_v) begin
            holder_grants[found_idx] <= holder_grants[found_idx] - 1'b1;
          end
          ev_status <= ST_RELEASED;
          ev_txn    <= '0;
          qi        <= '0;
          stage_ret <= S_WCHECK;
          state     <= S_STAGE;
        end
        S_WCHECK: begin
          if (qi >= wait_length || 32'(qi) >= REQUEST_SLOTS) begin
            state <= S_FINISH;
          end else if (conflicts(conflict_matrix, q_mode, gmask)) begin
            qi <= qi + 1'b1;
          end else begin
            wake_slot <= q_head;
            key       <= slot_txn[q_head];
            hi        <= '0;
            found_v   <= 1'b0;
            free_v    <= 1'b0;
            scan_ret  <= S_WAKE_DEC;
            state     <= S_HSCAN;
          end
        end
        S_WAKE_DEC: begin
          logic [HW-1:0] h;
          h = found_v ? found_idx : free_idx;
          if (!found_v && !free_v) begin
            qi    <= qi + 1'b1;
            state <= S_WCHECK;
          end else begin
            for (int i = 0; i < REQUEST_SLOTS - 1; i++) begin
              if (LW'(i) >= qi) wait_queue[i] <= wait_queue[i+1];
            end
            wait_length <= wait_length - 1'b1;
            if (waiting_cnt[slot_mode[wake_slot]] != '0) begin
              waiting_cnt[slot_mode[wake_slot]] <= waiting_cnt[slot_mode[wake_slot]] - 1'b1;
            end
            granted_cnt[slot_mode[wake_slot]] <= granted_cnt[slot_mode[wake_slot]] + 1'b1;
            holder_txn[h]    <= key;
            holder_grants[h] <= holder_grants[h] + 1'b1;
            slot_is_waiting[wake_slot] <= 1'b0;
            ev_status <= ST_WOKEN;
            ev_handle <= wake_slot;
            ev_txn    <= key;
            stage_ret <= S_WCHECK;
            state     <= S_STAGE;
          end
        end
        S_STAGE: begin
          // A word is held back one event so that its last flag is known.
          if (pend_valid) begin
            status        <= pend_status;
            handle        <= 4'(pend_handle);
            woken_txn     <= pend_txn;
            granted_modes <= pend_g;
            waiting_modes <= pend_w;
            last          <= 1'b0;
          end
          pend_valid  <= 1'b1;
          pend_status <= ev_status;
          pend_handle <= ev_handle;
          pend_txn    <= ev_txn;
          pend_g      <= gmask;
          pend_w      <= wmask;
          state       <= stage_ret;
        end
        S_FINISH: begin
          status        <= pend_status;
          handle        <= 4'(pend_handle);
          woken_txn     <= pend_txn;
          granted_modes <= pend_g;
          waiting_modes <= pend_w;
          last          <= 1'b1;
          pend_valid    <= 1'b0;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    32'(wait_length) <= REQUEST_SLOTS) else $error("wait queue overran");
  a_queue_in_used: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_is_waiting) == 32'(wait_length)) else $error("queue and slots disagree");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted word did not raise busy");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> !busy && !pend_valid) else $error("result after last");
endmodule
